### src/ray_capped_cylinder_pick_assert.svh
// Assertion macros shared by the capped cylinder pick RTL.
`ifndef RAY_CAPPED_CYLINDER_PICK_ASSERT_SVH
`define RAY_CAPPED_CYLINDER_PICK_ASSERT_SVH

`ifndef ASSERT_OFF

// Checked property, switched off while reset is high.
`define RCCP_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("rccp assertion failed");

// Checked property that also holds through reset.
`define RCCP_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("rccp assertion failed");

`else

`define RCCP_ASSERT(label, clk, rst, prop)
`define RCCP_ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

### src/rccp_pkg.sv
// Shared types, constants and Q16.16 arithmetic for the capped cylinder pick.
`default_nettype none

package rccp_pkg;

   typedef logic signed [31:0] fx_type;

   localparam fx_type FX_ONE     = 32'sd65536;
   localparam fx_type FX_NEG_ONE = -32'sd65536;
   localparam fx_type FX_MAX     = 32'sh7fff_ffff;
   localparam fx_type FX_MIN     = 32'sh8000_0000;

   // Square root: 48-bit radicand, one root bit per stage.
   localparam int SQRT_BITS = 24;
   localparam int RAD_W     = 2 * SQRT_BITS;
   // Division: one quotient bit per stage.
   localparam int DIV_BITS  = 32;
   localparam int NUM_DIVS  = 4;

   // Stage numbers of the pipeline.
   localparam int ST_PROD    = 0;
   localparam int ST_SUM     = 1;
   localparam int ST_BC      = 2;
   localparam int ST_SQR     = 3;
   localparam int ST_DISC    = 4;
   localparam int ST_NUM     = ST_DISC + SQRT_BITS + 1;
   localparam int ST_PREP    = ST_NUM + 1;
   localparam int ST_QUO     = ST_PREP + DIV_BITS + 1;
   localparam int ST_MUL     = ST_QUO + 1;
   localparam int ST_ADD     = ST_MUL + 1;
   localparam int ST_SQ2     = ST_ADD + 1;
   localparam int ST_SIDE    = ST_SQ2 + 1;
   localparam int ST_CAP     = ST_SIDE + 1;
   localparam int NUM_STAGES = ST_CAP + 1;

   // Indexes of the four divisions.
   localparam int DV_SIDE_TOP = 0;
   localparam int DV_SIDE_BOT = 1;
   localparam int DV_CAP_TOP  = 2;
   localparam int DV_CAP_BOT  = 3;

   // Ray data that travels along the pipeline.
   typedef struct packed {
      fx_type ox;
      fx_type oy;
      fx_type oz;
      fx_type dx;
      fx_type dy;
      fx_type dz;
      fx_type best;
      fx_type cnum_top;
      fx_type cnum_bot;
      fx_type den;
      fx_type nb;
      logic   side_ok;
      logic   cap_ok;
   } ctx_type;

   typedef struct packed {
      logic [RAD_W-1:0]     rad;
      logic [SQRT_BITS+1:0] rem;
      logic [SQRT_BITS-1:0] root;
   } sqrt_type;

   typedef struct packed {
      logic [31:0] rem;
      logic [31:0] low;
      logic [31:0] quo;
      logic [31:0] dmag;
      logic        neg;
      logic        dzero;
      logic        ovf;
      logic        nneg;
   } div_type;

   function automatic fx_type fx_sat(input logic signed [63:0] v);
      if (v > 64'sd2147483647) return FX_MAX;
      if (v < -64'sd2147483648) return FX_MIN;
      return v[31:0];
   endfunction

   function automatic fx_type fx_add(input fx_type a, input fx_type b);
      return fx_sat(64'(a) + 64'(b));
   endfunction

   function automatic fx_type fx_sub(input fx_type a, input fx_type b);
      return fx_sat(64'(a) - 64'(b));
   endfunction

   // Product rounded to nearest, ties toward plus infinity, then saturated.
   function automatic fx_type fx_mul(input fx_type a, input fx_type b);
      logic signed [63:0] p;
      p = 64'(a) * 64'(b);
      return fx_sat((p + 64'sd32768) >>> 16);
   endfunction

   // One restoring square root step: two radicand bits in, one root bit out.
   function automatic sqrt_type sqrt_step(input sqrt_type s);
      sqrt_type             r;
      logic [SQRT_BITS+3:0] rs;
      logic [SQRT_BITS+3:0] trial;
      rs     = {s.rem, s.rad[RAD_W-1 -: 2]};
      trial  = {2'b00, s.root, 2'b01};
      r.rad  = {s.rad[RAD_W-3:0], 2'b00};
      if (rs >= trial) begin
         r.rem  = (SQRT_BITS+2)'(rs - trial);
         r.root = {s.root[SQRT_BITS-2:0], 1'b1};
      end else begin
         r.rem  = (SQRT_BITS+2)'(rs);
         r.root = {s.root[SQRT_BITS-2:0], 1'b0};
      end
      return r;
   endfunction

   // Magnitudes, signs and overflow check for (a * 2^16) / b.
   function automatic div_type div_prep(input fx_type a, input fx_type b);
      div_type     r;
      logic [31:0] am;
      logic [31:0] bm;
      am      = a[31] ? 32'(-a) : 32'(a);
      bm      = b[31] ? 32'(-b) : 32'(b);
      r.dmag  = bm;
      r.dzero = (b == 32'sd0);
      r.nneg  = !a[31];
      r.neg   = a[31] ^ b[31];
      r.ovf   = ({16'h0, am[31:16]} >= bm);
      r.rem   = {16'h0, am[31:16]};
      r.low   = {am[15:0], 16'h0};
      r.quo   = '0;
      return r;
   endfunction

   // One restoring division step.
   function automatic div_type div_step(input div_type d);
      div_type     r;
      logic [32:0] rs;
      rs    = {d.rem, d.low[31]};
      r     = d;
      r.low = {d.low[30:0], 1'b0};
      if (rs >= {1'b0, d.dmag}) begin
         r.rem = 32'(rs - {1'b0, d.dmag});
         r.quo = {d.quo[30:0], 1'b1};
      end else begin
         r.rem = rs[31:0];
         r.quo = {d.quo[30:0], 1'b0};
      end
      return r;
   endfunction

   // Sign and saturation of the finished quotient.
   function automatic fx_type div_final(input div_type d);
      if (d.dzero) return d.nneg ? FX_MAX : FX_MIN;
      if (d.ovf) return d.neg ? FX_MIN : FX_MAX;
      if (d.neg) return (d.quo > 32'h8000_0000) ? FX_MIN : 32'h0 - d.quo;
      return (d.quo > 32'h7fff_ffff) ? FX_MAX : d.quo;
   endfunction

endpackage

`default_nettype wire

### src/rccp_req_if.sv
// Ray channel: valid, ready and one ray item.
`default_nettype none

interface rccp_req_if;
   import rccp_pkg::*;

   logic   valid;
   logic   ready;
   fx_type origin_x;
   fx_type origin_y;
   fx_type origin_z;
   fx_type dir_x;
   fx_type dir_y;
   fx_type dir_z;
   fx_type best_t;

   modport source (
      output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, best_t,
      input  ready
   );

   modport sink (
      input  valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, best_t,
      output ready
   );
endinterface

`default_nettype wire

### src/rccp_rsp_if.sv
// Result channel: valid, ready and one pick result item.
`default_nettype none

interface rccp_rsp_if;
   import rccp_pkg::*;

   logic   valid;
   logic   ready;
   logic   hit;
   fx_type new_t;
   fx_type hit_x;
   fx_type hit_y;
   fx_type hit_z;

   modport source (
      output valid, hit, new_t, hit_x, hit_y, hit_z,
      input  ready
   );

   modport sink (
      input  valid, hit, new_t, hit_x, hit_y, hit_z,
      output ready
   );
endinterface

`default_nettype wire

### src/ray_capped_cylinder_pick.sv
// Ray against capped unit cylinder pick, Q16.16, as one stallable pipeline.
// Throughput is one item per cycle unless the output stalls; the 24-stage square root and the four
// 32-stage dividers set the depth. A stalled output freezes every stage.
// Synchronous reset clears the valid bits only; no clearing pass is needed.
`default_nettype none

`include "ray_capped_cylinder_pick_assert.svh"

module ray_capped_cylinder_pick (
   input  logic       clock,
   input  logic       reset,
   rccp_req_if.sink   req_ch,
   rccp_rsp_if.source rsp_ch
);
   import rccp_pkg::*;

   localparam int CTX_LAST = ST_SQ2;

   logic                  adv;
   logic [NUM_STAGES-1:0] vld_ff, vld_in;

   ctx_type ctx_ff [CTX_LAST+1];
   ctx_type ctx_in [CTX_LAST+1];

   // Front products and sums.
   fx_type pdxx_ff, pdyy_ff, pdxo_ff, pdyo_ff, poxx_ff, poyy_ff;
   fx_type pdxx_in, pdyy_in, pdxo_in, pdyo_in, poxx_in, poyy_in;
   fx_type a_ff, s_ff, cp_ff, a_in, s_in, cp_in;
   fx_type b_ff, c_ff, fa_ff, a2_ff, b_in, c_in, fa_in, a2_in;
   fx_type bb_ff, fac_ff, a3_ff, b3_ff, bb_in, fac_in, a3_in, b3_in;
   fx_type disc;

   sqrt_type sq_ff [SQRT_BITS+1];
   sqrt_type sq_in [SQRT_BITS+1];

   fx_type num_top_ff, num_bot_ff, num_top_in, num_bot_in;

   div_type dv_ff [NUM_DIVS][DIV_BITS+1];
   div_type dv_in [NUM_DIVS][DIV_BITS+1];

   // Back end, candidates in order side top, side bottom, cap top, cap bottom.
   fx_type tq_ff [NUM_DIVS], tq_in [NUM_DIVS];
   fx_type mx_ff [NUM_DIVS], mx_in [NUM_DIVS];
   fx_type my_ff [NUM_DIVS], my_in [NUM_DIVS];
   fx_type mz_ff [2], mz_in [2];
   fx_type t2_ff [NUM_DIVS], t2_in [NUM_DIVS];
   fx_type px_ff [NUM_DIVS], px_in [NUM_DIVS];
   fx_type py_ff [NUM_DIVS], py_in [NUM_DIVS];
   fx_type z_ff [2], z_in [2];
   fx_type t3_ff [NUM_DIVS], t3_in [NUM_DIVS];
   fx_type uu_ff [2], uu_in [2];
   fx_type ww_ff [2], ww_in [2];
   fx_type px4_ff [NUM_DIVS], px4_in [NUM_DIVS];
   fx_type py4_ff [NUM_DIVS], py4_in [NUM_DIVS];
   fx_type z4_ff [2], z4_in [2];
   fx_type t4_ff [NUM_DIVS], t4_in [NUM_DIVS];

   // Side selection result and cap candidates.
   logic   sel_hit_ff, sel_hit_in;
   fx_type sel_best_ff, sel_px_ff, sel_py_ff, sel_pz_ff;
   fx_type sel_best_in, sel_px_in, sel_py_in, sel_pz_in;
   fx_type ct_ff [2], ct_in [2];
   fx_type cpx_ff [2], cpx_in [2];
   fx_type cpy_ff [2], cpy_in [2];
   logic   cok_ff [2], cok_in [2];

   // Output register.
   logic   out_hit_ff, out_hit_in;
   fx_type out_t_ff, out_x_ff, out_y_ff, out_z_ff;
   fx_type out_t_in, out_x_in, out_y_in, out_z_in;

   // The whole pipeline moves unless a finished item waits at the output.
   assign adv          = !vld_ff[ST_CAP] || rsp_ch.ready;
   assign req_ch.ready = adv;
   assign vld_in       = {vld_ff[NUM_STAGES-2:0], req_ch.valid};

   // Ray data: loaded from the item, then copied along with a few fills.
   always_comb begin
      ctx_in[0].ox       = req_ch.origin_x;
      ctx_in[0].oy       = req_ch.origin_y;
      ctx_in[0].oz       = req_ch.origin_z;
      ctx_in[0].dx       = req_ch.dir_x;
      ctx_in[0].dy       = req_ch.dir_y;
      ctx_in[0].dz       = req_ch.dir_z;
      ctx_in[0].best     = req_ch.best_t;
      ctx_in[0].cnum_top = fx_sub(FX_ONE, req_ch.origin_z);
      ctx_in[0].cnum_bot = fx_sub(FX_NEG_ONE, req_ch.origin_z);
      ctx_in[0].den      = '0;
      ctx_in[0].nb       = '0;
      ctx_in[0].side_ok  = 1'b0;
      ctx_in[0].cap_ok   = (req_ch.dir_z != 32'sd0);
      for (int k = 1; k <= CTX_LAST; k++) begin
         ctx_in[k] = ctx_ff[k-1];
      end
      ctx_in[ST_DISC].den     = fx_add(a3_ff, a3_ff);
      ctx_in[ST_DISC].nb      = fx_sub(32'sd0, b3_ff);
      ctx_in[ST_DISC].side_ok = !disc[31] && (a3_ff != 32'sd0);
   end

   // Quadratic coefficients and discriminant.
   always_comb begin
      pdxx_in = fx_mul(req_ch.dir_x, req_ch.dir_x);
      pdyy_in = fx_mul(req_ch.dir_y, req_ch.dir_y);
      pdxo_in = fx_mul(req_ch.dir_x, req_ch.origin_x);
      pdyo_in = fx_mul(req_ch.dir_y, req_ch.origin_y);
      poxx_in = fx_mul(req_ch.origin_x, req_ch.origin_x);
      poyy_in = fx_mul(req_ch.origin_y, req_ch.origin_y);
      a_in    = fx_add(pdxx_ff, pdyy_ff);
      s_in    = fx_add(pdxo_ff, pdyo_ff);
      cp_in   = fx_add(poxx_ff, poyy_ff);
      b_in    = fx_add(s_ff, s_ff);
      c_in    = fx_sub(cp_ff, FX_ONE);
      fa_in   = fx_sat(64'(a_ff) <<< 2);
      a2_in   = a_ff;
      bb_in   = fx_mul(b_ff, b_ff);
      fac_in  = fx_mul(fa_ff, c_ff);
      a3_in   = a2_ff;
      b3_in   = b_ff;
      disc    = fx_sub(bb_ff, fac_ff);
   end

   // Square root of the discriminant, one root bit per stage.
   always_comb begin
      sq_in[0].rad  = disc[31] ? '0 : {disc, 16'h0};
      sq_in[0].rem  = '0;
      sq_in[0].root = '0;
      for (int i = 0; i < SQRT_BITS; i++) begin
         sq_in[i+1] = sqrt_step(sq_ff[i]);
      end
      num_top_in = fx_add(ctx_ff[ST_NUM-1].nb, 32'(sq_ff[SQRT_BITS].root));
      num_bot_in = fx_sub(ctx_ff[ST_NUM-1].nb, 32'(sq_ff[SQRT_BITS].root));
   end

   // Four dividers side by side, one quotient bit per stage.
   always_comb begin
      dv_in[DV_SIDE_TOP][0] = div_prep(num_top_ff, ctx_ff[ST_PREP-1].den);
      dv_in[DV_SIDE_BOT][0] = div_prep(num_bot_ff, ctx_ff[ST_PREP-1].den);
      dv_in[DV_CAP_TOP][0]  = div_prep(ctx_ff[ST_PREP-1].cnum_top, ctx_ff[ST_PREP-1].dz);
      dv_in[DV_CAP_BOT][0]  = div_prep(ctx_ff[ST_PREP-1].cnum_bot, ctx_ff[ST_PREP-1].dz);
      for (int j = 0; j < NUM_DIVS; j++) begin
         for (int i = 0; i < DIV_BITS; i++) begin
            dv_in[j][i+1] = div_step(dv_ff[j][i]);
         end
      end
   end

   // Candidate points and cap radius test.
   always_comb begin
      for (int j = 0; j < NUM_DIVS; j++) begin
         tq_in[j]  = div_final(dv_ff[j][DIV_BITS]);
         mx_in[j]  = fx_mul(tq_ff[j], ctx_ff[ST_MUL-1].dx);
         my_in[j]  = fx_mul(tq_ff[j], ctx_ff[ST_MUL-1].dy);
         t2_in[j]  = tq_ff[j];
         px_in[j]  = fx_add(ctx_ff[ST_ADD-1].ox, mx_ff[j]);
         py_in[j]  = fx_add(ctx_ff[ST_ADD-1].oy, my_ff[j]);
         t3_in[j]  = t2_ff[j];
         px4_in[j] = px_ff[j];
         py4_in[j] = py_ff[j];
         t4_in[j]  = t3_ff[j];
      end
      for (int k = 0; k < 2; k++) begin
         mz_in[k] = fx_mul(tq_ff[k], ctx_ff[ST_MUL-1].dz);
         z_in[k]  = fx_add(ctx_ff[ST_ADD-1].oz, mz_ff[k]);
         z4_in[k] = z_ff[k];
         uu_in[k] = fx_mul(px_ff[DV_CAP_TOP+k], px_ff[DV_CAP_TOP+k]);
         ww_in[k] = fx_mul(py_ff[DV_CAP_TOP+k], py_ff[DV_CAP_TOP+k]);
      end
   end

   // Side roots in order, each must be strictly nearer than the best so far.
   always_comb begin
      sel_hit_in  = 1'b0;
      sel_best_in = ctx_ff[ST_SIDE-1].best;
      sel_px_in   = '0;
      sel_py_in   = '0;
      sel_pz_in   = '0;
      for (int k = 0; k < 2; k++) begin
         if (ctx_ff[ST_SIDE-1].side_ok && z4_ff[k] < FX_ONE && z4_ff[k] > FX_NEG_ONE &&
             sel_best_in > t4_ff[k]) begin
            sel_hit_in  = 1'b1;
            sel_best_in = t4_ff[k];
            sel_px_in   = px4_ff[k];
            sel_py_in   = py4_ff[k];
            sel_pz_in   = z4_ff[k];
         end
      end
      for (int k = 0; k < 2; k++) begin
         ct_in[k]  = t4_ff[DV_CAP_TOP+k];
         cpx_in[k] = px4_ff[DV_CAP_TOP+k];
         cpy_in[k] = py4_ff[DV_CAP_TOP+k];
         cok_in[k] = ctx_ff[ST_SIDE-1].cap_ok && (fx_add(uu_ff[k], ww_ff[k]) < FX_ONE);
      end
   end

   // End discs, top then bottom.
   always_comb begin
      out_hit_in = sel_hit_ff;
      out_t_in   = sel_best_ff;
      out_x_in   = sel_px_ff;
      out_y_in   = sel_py_ff;
      out_z_in   = sel_pz_ff;
      for (int k = 0; k < 2; k++) begin
         if (cok_ff[k] && out_t_in > ct_ff[k]) begin
            out_hit_in = 1'b1;
            out_t_in   = ct_ff[k];
            out_x_in   = cpx_ff[k];
            out_y_in   = cpy_ff[k];
            out_z_in   = (k == 0) ? FX_ONE : FX_NEG_ONE;
         end
      end
   end

   // Valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   // Payload registers of all stages.
   always_ff @(posedge clock) begin
      if (adv) begin
         ctx_ff      <= ctx_in;
         pdxx_ff     <= pdxx_in;
         pdyy_ff     <= pdyy_in;
         pdxo_ff     <= pdxo_in;
         pdyo_ff     <= pdyo_in;
         poxx_ff     <= poxx_in;
         poyy_ff     <= poyy_in;
         a_ff        <= a_in;
         s_ff        <= s_in;
         cp_ff       <= cp_in;
         b_ff        <= b_in;
         c_ff        <= c_in;
         fa_ff       <= fa_in;
         a2_ff       <= a2_in;
         bb_ff       <= bb_in;
         fac_ff      <= fac_in;
         a3_ff       <= a3_in;
         b3_ff       <= b3_in;
         sq_ff       <= sq_in;
         num_top_ff  <= num_top_in;
         num_bot_ff  <= num_bot_in;
         dv_ff       <= dv_in;
         tq_ff       <= tq_in;
         mx_ff       <= mx_in;
         my_ff       <= my_in;
         mz_ff       <= mz_in;
         t2_ff       <= t2_in;
         px_ff       <= px_in;
         py_ff       <= py_in;
         z_ff        <= z_in;
         t3_ff       <= t3_in;
         uu_ff       <= uu_in;
         ww_ff       <= ww_in;
         px4_ff      <= px4_in;
         py4_ff      <= py4_in;
         z4_ff       <= z4_in;
         t4_ff       <= t4_in;
         sel_hit_ff  <= sel_hit_in;
         sel_best_ff <= sel_best_in;
         sel_px_ff   <= sel_px_in;
         sel_py_ff   <= sel_py_in;
         sel_pz_ff   <= sel_pz_in;
         ct_ff       <= ct_in;
         cpx_ff      <= cpx_in;
         cpy_ff      <= cpy_in;
         cok_ff      <= cok_in;
         out_hit_ff  <= out_hit_in;
         out_t_ff    <= out_t_in;
         out_x_ff    <= out_x_in;
         out_y_ff    <= out_y_in;
         out_z_ff    <= out_z_in;
      end
   end

   // Result item.
   assign rsp_ch.valid = vld_ff[ST_CAP];
   assign rsp_ch.hit   = out_hit_ff;
   assign rsp_ch.new_t = out_t_ff;
   assign rsp_ch.hit_x = out_x_ff;
   assign rsp_ch.hit_y = out_y_ff;
   assign rsp_ch.hit_z = out_z_ff;

   // A miss reports the origin point of the frame.
   `RCCP_ASSERT(a_miss_point_zero, clock, reset, rsp_ch.valid && !rsp_ch.hit |-> rsp_ch.hit_x == 32'sd0 && rsp_ch.hit_y == 32'sd0 && rsp_ch.hit_z == 32'sd0)
   // Any hit lies on the closed height range of the cylinder.
   `RCCP_ASSERT(a_hit_z_range, clock, reset, rsp_ch.valid && rsp_ch.hit |-> rsp_ch.hit_z <= FX_ONE && rsp_ch.hit_z >= FX_NEG_ONE)
   // A stall holds every valid bit.
   `RCCP_ASSERT(a_stall_holds, clock, reset, !adv |=> $stable(vld_ff))
   // An accepted item occupies the first stage in the next cycle.
   `RCCP_ASSERT(a_accept_enters, clock, reset, req_ch.valid && req_ch.ready |=> vld_ff[ST_PROD])

endmodule

`default_nettype wire

### tb/sv/rccp_tb_channels.sv
// Testbench copy of the ray and pick result channel interfaces is not needed; this file is empty.

### tb/sv/testbench.sv
// Testbench for the capped cylinder pick: random and directed rays checked against a predictor.
`default_nettype none

module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import rccp_pkg::*;

   localparam int CYCLE_LIMIT = 200000;

   typedef struct {
      fx_type ox, oy, oz, dx, dy, dz, best;
   } ray_type;

   typedef struct {
      logic   hit;
      fx_type t, px, py, pz;
   } pick_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   rccp_req_if ray_ch ();
   rccp_rsp_if pick_ch ();

   ray_capped_cylinder_pick dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (ray_ch.sink),
      .rsp_ch (pick_ch.source)
   );

   always #6 clock = ~clock;

   ray_type  ray_queue[$];
   pick_type expected_picks[$];
   int       error_count = 0;
   bit       stimulus_done = 0;
   int       cycle_count = 0;
   int       hold_off = 0;

   // Saturating Q16.16 arithmetic, written independently of the package.
   function automatic fx_type sat64(input longint v);
      if (v > 64'sd2147483647) return 32'sh7fff_ffff;
      if (v < -64'sd2147483648) return 32'sh8000_0000;
      return fx_type'(v[31:0]);
   endfunction

   function automatic fx_type q_add(input fx_type a, input fx_type b);
      return sat64(longint'(a) + longint'(b));
   endfunction

   function automatic fx_type q_sub(input fx_type a, input fx_type b);
      return sat64(longint'(a) - longint'(b));
   endfunction

   function automatic fx_type q_mul(input fx_type a, input fx_type b);
      longint p;
      p = longint'(a) * longint'(b) + 32768;
      return sat64(p >>> 16);
   endfunction

   function automatic fx_type q_div(input fx_type a, input fx_type b);
      if (b == 0) return a >= 0 ? 32'sh7fff_ffff : 32'sh8000_0000;
      return sat64((longint'(a) * 65536) / longint'(b));
   endfunction

   // Integer square root of v * 2^16 by bit pairs.
   function automatic fx_type q_sqrt(input fx_type v);
      longint unsigned n, res, bitv;
      if (v <= 0) return 0;
      n = longint'(v) << 16;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv >>= 2;
      while (bitv != 0) begin
         if (n >= res + bitv) begin
            n -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return fx_type'(res[31:0]);
   endfunction

   // Nearest intersection with the open side and the two end discs.
   function automatic pick_type predict_pick(input ray_type r);
      pick_type o;
      fx_type   a, s, b, c, d, t, z, u, w, root, den, nb, plane, best;
      best = r.best;
      o = '{1'b0, 0, 0, 0, 0};
      a = q_add(q_mul(r.dx, r.dx), q_mul(r.dy, r.dy));
      s = q_add(q_mul(r.dx, r.ox), q_mul(r.dy, r.oy));
      b = q_add(s, s);
      c = q_sub(q_add(q_mul(r.ox, r.ox), q_mul(r.oy, r.oy)), FX_ONE);
      d = q_sub(q_mul(b, b), q_mul(q_mul(32'sd262144, a), c));
      if (d >= 0 && a != 0) begin
         root = q_sqrt(d);
         den = q_add(a, a);
         nb = q_sub(0, b);
         for (int i = 0; i < 2; i++) begin
            t = q_div(i == 0 ? q_add(nb, root) : q_sub(nb, root), den);
            z = q_add(r.oz, q_mul(t, r.dz));
            if (z < FX_ONE && z > FX_NEG_ONE && best > t) begin
               o.hit = 1'b1;
               best = t;
               o.px = q_add(r.ox, q_mul(t, r.dx));
               o.py = q_add(r.oy, q_mul(t, r.dy));
               o.pz = z;
            end
         end
      end
      if (r.dz != 0) begin
         for (int i = 0; i < 2; i++) begin
            plane = (i == 0) ? FX_ONE : FX_NEG_ONE;
            t = q_div(q_sub(plane, r.oz), r.dz);
            if (t <= best) begin
               u = q_add(q_mul(t, r.dx), r.ox);
               w = q_add(q_mul(t, r.dy), r.oy);
               if (q_add(q_mul(u, u), q_mul(w, w)) < FX_ONE && best > t) begin
                  o.hit = 1'b1;
                  best = t;
                  o.px = u;
                  o.py = w;
                  o.pz = plane;
               end
            end
         end
      end
      o.t = best;
      return o;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("ERROR at cycle %0d: %s got %h expected %h", cycle_count, what, got, want);
      error_count++;
   endtask

   // Appends one ray to the list of pending items.
   task automatic enqueue_ray(input ray_type r);
      ray_queue.insert(ray_queue.size(), r);
   endtask

   function automatic fx_type any_word();
      return fx_type'($urandom);
   endfunction

   // A value near the unit cylinder, up to about four units away.
   function automatic fx_type near_word();
      return fx_type'(int'($urandom_range(0, 524288)) - 262144);
   endfunction

   function automatic ray_type random_ray();
      ray_type r;
      case ($urandom_range(0, 9))
         0: r = '{any_word(), any_word(), any_word(), any_word(), any_word(),
                  any_word(), any_word()};
         1: r = '{near_word(), near_word(), near_word(), near_word(), near_word(),
                  0, near_word()};
         2: r = '{near_word(), near_word(), near_word(), 0, 0, near_word(),
                  32'sh7fff_ffff};
         default: r = '{near_word(), near_word(), near_word(), near_word(),
                        near_word(), near_word(),
                        ($urandom_range(0, 3) == 0) ? near_word() : 32'sh7fff_ffff};
      endcase
      return r;
   endfunction

   // Directed rays first, then random ones.
   initial begin
      fx_type far;
      far = 32'sh7fff_ffff;
      enqueue_ray('{-32'sd196608, 0, 0, 32'sd65536, 0, 0, far});
      enqueue_ray('{0, 0, 32'sd196608, 0, 0, -32'sd65536, far});
      enqueue_ray('{0, 0, -32'sd196608, 0, 0, 32'sd65536, far});
      enqueue_ray('{32'sd32768, 0, 32'sd196608, 0, 0, 32'sd65536, far});
      enqueue_ray('{-32'sd196608, 0, 0, 32'sd65536, 0, 0, 32'sd65536});
      enqueue_ray('{-32'sd196608, 0, 0, 32'sd65536, 0, 0, -32'sd65536});
      enqueue_ray('{32'sd196608, 32'sd196608, 0, 0, 32'sd65536, 0, far});
      enqueue_ray('{0, 0, 0, 0, 0, 0, far});
      enqueue_ray('{0, 0, 0, 0, 0, 32'sd65536, far});
      enqueue_ray('{0, 0, 0, 32'sd65536, 32'sd65536, 0, far});
      enqueue_ray('{far, far, far, far, far, far, far});
      enqueue_ray('{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                    32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                    32'sh8000_0000});
      enqueue_ray('{far, 32'sh8000_0000, 0, 32'sh8000_0000, far, 1, far});
      enqueue_ray('{-1, -1, -1, -1, -1, -1, -1});
      enqueue_ray('{0, 0, 32'sd65536, 1, 1, 1, far});
      enqueue_ray('{0, 0, -32'sd196608, 0, 0, 32'sd1, far});
      for (int i = 0; i < 540; i++) enqueue_ray(random_ray());
   end

   // Reset is held at the start, then released.
   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
   end

   // Sender: waits a random gap before each ray, drives at the rising edge.
   int  send_gap = 0;
   always @(posedge clock) begin
      if (reset) begin
         ray_ch.valid <= 1'b0;
         ray_ch.origin_x <= '0; ray_ch.origin_y <= '0; ray_ch.origin_z <= '0;
         ray_ch.dir_x <= '0; ray_ch.dir_y <= '0; ray_ch.dir_z <= '0;
         ray_ch.best_t <= '0;
      end else begin
         if (ray_ch.valid && ray_ch.ready) begin
            expected_picks.insert(expected_picks.size(),
               predict_pick('{ray_ch.origin_x, ray_ch.origin_y, ray_ch.origin_z,
                              ray_ch.dir_x, ray_ch.dir_y, ray_ch.dir_z,
                              ray_ch.best_t}));
         end
         if (ray_ch.valid && !ray_ch.ready) begin
            // Hold the offered ray.
         end else if (send_gap > 0) begin
            send_gap <= send_gap - 1;
            ray_ch.valid <= 1'b0;
         end else if (ray_queue.size() > 0) begin
            ray_type r;
            r = ray_queue.pop_front();
            ray_ch.valid <= 1'b1;
            ray_ch.origin_x <= r.ox; ray_ch.origin_y <= r.oy; ray_ch.origin_z <= r.oz;
            ray_ch.dir_x <= r.dx; ray_ch.dir_y <= r.dy; ray_ch.dir_z <= r.dz;
            ray_ch.best_t <= r.best;
            send_gap <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 17) : 0;
         end else begin
            ray_ch.valid <= 1'b0;
            stimulus_done <= 1'b1;
         end
      end
   end

   // Counter for the long receiver hold-off.
   always @(posedge clock) begin
      if (!reset && cycle_count >= 200 && hold_off < 300) begin
         hold_off <= hold_off + 1;
      end
   end

   // Receiver: a long hold-off early on, then random stalls; checks each result.
   int  recv_gap = 0;
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (reset) begin
         pick_ch.ready <= 1'b0;
      end else begin
         if (pick_ch.valid && pick_ch.ready) begin
            if (expected_picks.size() == 0) begin
               report_mismatch("unexpected result", pick_ch.new_t, 0);
            end else begin
               pick_type e;
               e = expected_picks.pop_front();
               if (pick_ch.hit !== e.hit)
                  report_mismatch("hit", 32'(pick_ch.hit), 32'(e.hit));
               if (pick_ch.new_t !== e.t) report_mismatch("new_t", pick_ch.new_t, e.t);
               if (pick_ch.hit_x !== e.px) report_mismatch("hit_x", pick_ch.hit_x, e.px);
               if (pick_ch.hit_y !== e.py) report_mismatch("hit_y", pick_ch.hit_y, e.py);
               if (pick_ch.hit_z !== e.pz) report_mismatch("hit_z", pick_ch.hit_z, e.pz);
            end
         end
         if (cycle_count >= 200 && hold_off < 300) begin
            pick_ch.ready <= 1'b0;
         end else if (recv_gap > 0) begin
            recv_gap <= recv_gap - 1;
            pick_ch.ready <= 1'b0;
         end else begin
            pick_ch.ready <= 1'b1;
            if (pick_ch.valid && pick_ch.ready && $urandom_range(0, 3) == 0)
               recv_gap <= $urandom_range(0, 17);
         end
      end
   end

   // End of run: drain, settle, then judge; or time out.
   initial begin
      wait (stimulus_done || cycle_count >= CYCLE_LIMIT);
      while (expected_picks.size() != 0 && cycle_count < CYCLE_LIMIT) @(posedge clock);
      repeat (80) @(posedge clock);
      if (cycle_count >= CYCLE_LIMIT || !stimulus_done) begin
         $display("Simulation FAILED");
      end else if (error_count == 0 && expected_picks.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire
